@@ rtl/ctrp_pkg.sv @@
// Package for the crank tooth rpm meter: controller states, command and status
// structs, register indexes, reset values and divider constants.
// Depends on nothing; every other file imports it.
package ctrp_pkg;

    localparam int DATA_W   = 32;
    localparam int RPM_W    = 26;
    localparam int TOOTH_W  = 8;
    localparam int DEB_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEETH_PER_REV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD    = 3'd4;

    // Register values after reset.
    localparam logic [DEB_W-1:0]   DEBOUNCE_RST      = 16'd200;
    localparam logic [DATA_W-1:0]  STALL_TIMEOUT_RST = 32'd1000000;
    localparam logic [TOOTH_W-1:0] TEETH_PER_REV_RST = 8'd11;
    localparam logic [DATA_W-1:0]  MIN_PERIOD_RST    = 32'd6000;
    localparam logic [DATA_W-1:0]  MAX_PERIOD_RST    = 32'd200000;

    // The dividend fits in RPM_W bits, so the divider runs one step per bit.
    localparam logic [RPM_W-1:0] RPM_NUMERATOR = 26'd60000000;
    localparam int               DIV_STEPS     = RPM_W;
    localparam int               DIV_CNT_W     = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } ctrp_state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic div_step;
        logic out_load;
    } ctrp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } ctrp_stat_t;

endpackage

@@ rtl/ctrp_if.sv @@
// Channel interfaces of the crank tooth rpm meter: edge items, result items
// and configuration writes. Depends on ctrp_pkg for field widths.
interface ctrp_edge_if
    import ctrp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] edge_time_us;

    modport source (output valid, output edge_time_us, input ready);
    modport sink   (input valid, input edge_time_us, output ready);
endinterface

interface ctrp_result_if
    import ctrp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [RPM_W-1:0]   rpm_value;
    logic               edge_accepted;
    logic               stall_detected;
    logic               rev_complete;
    logic               rpm_updated;
    logic [TOOTH_W-1:0] tooth_index;

    modport source (output valid, output rpm_value, output edge_accepted,
                    output stall_detected, output rev_complete, output rpm_updated,
                    output tooth_index, input ready);
    modport sink   (input valid, input rpm_value, input edge_accepted,
                    input stall_detected, input rev_complete, input rpm_updated,
                    input tooth_index, output ready);
endinterface

interface ctrp_cfg_if
    import ctrp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/ctrp_ctrl.sv @@
// Controller of the crank tooth rpm meter: sequences capture, evaluation,
// division and the hand-over to the output register. Depends on ctrp_pkg.
module ctrp_ctrl
    import ctrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  ctrp_stat_t stat,
    output ctrp_cmd_t  cmd
);

    ctrp_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    // The output slot is free when empty or when its item leaves this cycle.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = stat.need_div ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/ctrp_dp.sv @@
// Datapath of the crank tooth rpm meter: configuration registers, edge state,
// the bit-serial rpm divider and the output register. Depends on ctrp_pkg.
module ctrp_dp
    import ctrp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrp_cmd_t            cmd,
    output ctrp_stat_t           stat,
    input  logic [DATA_W-1:0]    edge_time_us,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output logic [RPM_W-1:0]     rpm_value,
    output logic                 edge_accepted,
    output logic                 stall_detected,
    output logic                 rev_complete,
    output logic                 rpm_updated,
    output logic [TOOTH_W-1:0]   tooth_index
);

    // Configuration.
    logic [DEB_W-1:0]   debounce_reg;
    logic [DATA_W-1:0]  timeout_reg;
    logic [TOOTH_W-1:0] teeth_reg;
    logic [DATA_W-1:0]  min_period_reg;
    logic [DATA_W-1:0]  max_period_reg;

    // Edge state.
    logic [DATA_W-1:0]  last_edge_reg, last_edge_next;
    logic [DATA_W-1:0]  last_rev_reg, last_rev_next;
    logic [TOOTH_W-1:0] tooth_reg, tooth_next;
    logic [RPM_W-1:0]   rpm_reg, rpm_next;

    // Item in flight and its flags.
    logic [DATA_W-1:0]  now_reg;
    logic               acc_reg, acc_next;
    logic               stall_reg, stall_next;
    logic               rev_reg, rev_next;
    logic               upd_reg, upd_next;

    // Divider: the quotient register starts out holding the dividend.
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [RPM_W-1:0]     quo_reg, quo_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    // Output register.
    logic [RPM_W-1:0]   o_rpm_reg;
    logic               o_acc_reg, o_stall_reg, o_rev_reg, o_upd_reg;
    logic [TOOTH_W-1:0] o_tooth_reg;

    logic [DATA_W-1:0]  gap, period;
    logic               is_stall, is_acc, is_rev, in_win, is_upd;
    logic [TOOTH_W:0]   cnt_inc;
    logic [DATA_W:0]    trial;
    logic               q_bit;
    logic [DATA_W-1:0]  rem_step;
    logic [RPM_W-1:0]   quo_step;

    assign gap      = now_reg - last_edge_reg;
    assign period   = now_reg - last_rev_reg;
    assign is_stall = gap > timeout_reg;
    assign is_acc   = !is_stall && (gap >= {{(DATA_W-DEB_W){1'b0}}, debounce_reg});
    assign cnt_inc  = {1'b0, tooth_reg} + {{TOOTH_W{1'b0}}, 1'b1};
    assign is_rev   = cnt_inc >= {1'b0, teeth_reg};
    assign in_win   = (period > min_period_reg) && (period < max_period_reg);
    assign is_upd   = is_acc && is_rev && in_win;

    // One restoring step: the partial remainder stays below the divisor.
    assign trial    = {rem_reg, quo_reg[RPM_W-1]};
    assign q_bit    = trial >= {1'b0, dvs_reg};
    assign rem_step = q_bit ? DATA_W'(trial - {1'b0, dvs_reg}) : trial[DATA_W-1:0];
    assign quo_step = {quo_reg[RPM_W-2:0], q_bit};

    assign stat.need_div = is_upd;
    assign stat.div_last = cnt_reg == DIV_LAST;

    always_comb
    begin
        last_edge_next = last_edge_reg;
        last_rev_next  = last_rev_reg;
        tooth_next     = tooth_reg;
        rpm_next       = rpm_reg;
        acc_next       = acc_reg;
        stall_next     = stall_reg;
        rev_next       = rev_reg;
        upd_next       = upd_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        if (cmd.eval)
        begin
            acc_next   = is_acc;
            stall_next = is_stall;
            rev_next   = is_acc && is_rev;
            upd_next   = is_upd;
            if (is_stall)
            begin
                rpm_next       = '0;
                tooth_next     = '0;
                last_edge_next = now_reg;
                last_rev_next  = now_reg;
            end
            else if (is_acc)
            begin
                last_edge_next = now_reg;
                if (is_rev)
                begin
                    last_rev_next = now_reg;
                    tooth_next    = '0;
                end
                else
                begin
                    tooth_next = cnt_inc[TOOTH_W-1:0];
                end
            end
            rem_next = '0;
            quo_next = RPM_NUMERATOR;
            dvs_next = period;
            cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            rem_next = rem_step;
            quo_next = quo_step;
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (stat.div_last)
            begin
                rpm_next = quo_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RST;
            timeout_reg    <= STALL_TIMEOUT_RST;
            teeth_reg      <= TEETH_PER_REV_RST;
            min_period_reg <= MIN_PERIOD_RST;
            max_period_reg <= MAX_PERIOD_RST;
            last_edge_reg  <= '0;
            last_rev_reg   <= '0;
            tooth_reg      <= '0;
            rpm_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEBOUNCE:      debounce_reg   <= cfg_data[DEB_W-1:0];
                    REG_STALL_TIMEOUT: timeout_reg    <= cfg_data;
                    REG_TEETH_PER_REV: teeth_reg      <= cfg_data[TOOTH_W-1:0];
                    REG_MIN_PERIOD:    min_period_reg <= cfg_data;
                    REG_MAX_PERIOD:    max_period_reg <= cfg_data;
                    default:           ;
                endcase
            end
            last_edge_reg <= last_edge_next;
            last_rev_reg  <= last_rev_next;
            tooth_reg     <= tooth_next;
            rpm_reg       <= rpm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg <= edge_time_us;
        end
        acc_reg   <= acc_next;
        stall_reg <= stall_next;
        rev_reg   <= rev_next;
        upd_reg   <= upd_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        cnt_reg   <= cnt_next;
        if (cmd.out_load)
        begin
            o_rpm_reg   <= rpm_reg;
            o_acc_reg   <= acc_reg;
            o_stall_reg <= stall_reg;
            o_rev_reg   <= rev_reg;
            o_upd_reg   <= upd_reg;
            o_tooth_reg <= tooth_reg;
        end
    end

    assign rpm_value      = o_rpm_reg;
    assign edge_accepted  = o_acc_reg;
    assign stall_detected = o_stall_reg;
    assign rev_complete   = o_rev_reg;
    assign rpm_updated    = o_upd_reg;
    assign tooth_index    = o_tooth_reg;

endmodule

@@ rtl/crank_tooth_rpm_meter.sv @@
// Crank tooth rpm meter.
// Channels: crank carries one falling-edge item with its 32-bit microsecond
// timestamp; result returns exactly one item per edge with the rpm, the tooth
// index and flags for a counted tooth, a stall, a finished revolution and an
// rpm update; cfg writes the five registers by index and is always ready.
// Configuration must be written by the user only while no edge is in flight;
// the block does not enforce this. Each edge is captured in ST_IDLE and
// evaluated in ST_EVAL, and one that brings no new rpm then goes to ST_DONE.
// An edge that completes a revolution inside the window first runs the
// restoring divider for 60000000 / period, one quotient bit per cycle.
// ST_DONE loads the result into the output register once the slot is free.
// Crank takes no new edge before that load and is ready the cycle after it.
// The output register holds a finished item while the receiver stalls; the
// next edge is taken meanwhile, and its result waits until the slot frees.
// Reset clears rpm, the tooth count and both time marks, restores the
// register defaults and empties the output register.
// Depends on ctrp_pkg, the interfaces, ctrp_ctrl and ctrp_dp.
module crank_tooth_rpm_meter
    import ctrp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    ctrp_edge_if.sink     crank,
    ctrp_result_if.source result,
    ctrp_cfg_if.sink      cfg
);

    ctrp_cmd_t  cmd;
    ctrp_stat_t stat;

    assign cfg.ready = 1'b1;

    ctrp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (crank.valid),
        .in_ready  (crank.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ctrp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .edge_time_us   (crank.edge_time_us),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .rpm_value      (result.rpm_value),
        .edge_accepted  (result.edge_accepted),
        .stall_detected (result.stall_detected),
        .rev_complete   (result.rev_complete),
        .rpm_updated    (result.rpm_updated),
        .tooth_index    (result.tooth_index)
    );

endmodule
